>>> design/sonar_zone_alarm_classifier_top_macros.svh
// ----------------------------------------------------------------------------
// Sonar zone alarm classifier: assertion macros
// Concurrent assertion wrappers that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SONAR_ZONE_ALARM_CLASSIFIER_TOP_MACROS_SVH
`define SONAR_ZONE_ALARM_CLASSIFIER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Checked only out of reset.
`define SZAC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("szac assertion failed");
// Checked at every edge, reset included.
`define SZAC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("szac assertion failed");
`else
`define SZAC_ASSERT(label, prop)
`define SZAC_ASSERT_ALWAYS(label, prop)
`endif

`endif

>>> design/szac_pkg.sv
// ----------------------------------------------------------------------------
// Sonar zone alarm classifier package
// Shared types, constants and helpers of the classifier.
// ----------------------------------------------------------------------------
package szac_pkg;

  localparam int unsigned LEVELS = 3;
  localparam int unsigned NUM_CH = 2;
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  localparam logic [3:0] MISS_MAX       = 4'd15;
  localparam logic [3:0] MISS_LIMIT_RST = 4'd10;

  localparam logic ACT_POLL  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef enum logic [1:0] {
    LVL_CLEAR = 2'd0,
    LVL_WARN  = 2'd1,
    LVL_SLOW  = 2'd2,
    LVL_STOP  = 2'd3
  } alarm_e;

  typedef struct packed {
    alarm_e      alarm_level;
    logic [2:0]  area_index;
    logic        area_active;
    logic [2:0]  drive_bits;
    logic [1:0]  alive_flags;
    logic [15:0] distance_a;
    logic [15:0] distance_b;
  } result_t;

  function automatic logic [2:0] thermo(input alarm_e lvl);
    logic [2:0] res;
    case (lvl)
      LVL_CLEAR: res = 3'b000;
      LVL_WARN:  res = 3'b001;
      LVL_SLOW:  res = 3'b011;
      LVL_STOP:  res = 3'b111;
      default:   res = 3'b000;
    endcase
    return res;
  endfunction

endpackage

>>> design/sonar_zone_alarm_classifier_top.sv
// ----------------------------------------------------------------------------
// Sonar zone alarm classifier
// Two-channel sonar health tracking and zone-based alarm level classification.
// ----------------------------------------------------------------------------
//  channel   | handshake             | payload
//  ----------+-----------------------+---------------------------------------
//  config    | cfg_we_i              | cfg_wdata_i (miss limit)
//  input     | in_valid_i/in_stall_o | action, channel, reply_ok, distance,
//            |                       | zone_inputs, area_slot, level_sel, thr
//  result    | out_valid_o/out_stall_i | alarm_level ... distance_b
//
//  One item per cycle is accepted unless the input stalls. A poll's result is
//  registered with the threshold RAM read, then queued; writes give no result.
//  Reset clears channel health and sets the miss limit to 10; thresholds are
//  undefined until written. Input stalls only when the two-entry result queue
//  is full and a classified poll is waiting to enter it.
// ----------------------------------------------------------------------------
module sonar_zone_alarm_classifier_top #(
  parameter int unsigned AREAS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic        channel_i,
  input  logic        reply_ok_i,
  input  logic [15:0] distance_i,
  input  logic [3:0]  zone_inputs_i,
  input  logic [2:0]  area_slot_i,
  input  logic [1:0]  level_sel_i,
  input  logic [15:0] threshold_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  alarm_level_o,
  output logic [2:0]  area_index_o,
  output logic        area_active_o,
  output logic [2:0]  drive_bits_o,
  output logic [1:0]  alive_flags_o,
  output logic [15:0] distance_a_o,
  output logic [15:0] distance_b_o
);
  import szac_pkg::*;

`include "sonar_zone_alarm_classifier_top_macros.svh"

  logic    q_full, push_valid;
  result_t push_data, head;

  szac_front #(
    .AREAS (AREAS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .channel_i     (channel_i),
    .reply_ok_i    (reply_ok_i),
    .distance_i    (distance_i),
    .zone_inputs_i (zone_inputs_i),
    .area_slot_i   (area_slot_i),
    .level_sel_i   (level_sel_i),
    .threshold_i   (threshold_i),
    .q_full_i      (q_full),
    .push_valid_o  (push_valid),
    .push_data_o   (push_data)
  );

  szac_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_data_i (push_data),
    .full_o      (q_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign alarm_level_o = head.alarm_level;
  assign area_index_o  = head.area_index;
  assign area_active_o = head.area_active;
  assign drive_bits_o  = head.drive_bits;
  assign alive_flags_o = head.alive_flags;
  assign distance_a_o  = head.distance_a;
  assign distance_b_o  = head.distance_b;

  `SZAC_ASSERT_ALWAYS(a_stall_only_when_full, in_stall_o |-> q_full)
  `SZAC_ASSERT(a_no_push_when_full, push_valid |-> !q_full)
  `SZAC_ASSERT(a_no_alarm_outside_area,
               (out_valid_o && !area_active_o) |-> (alarm_level_o == LVL_CLEAR))
  `SZAC_ASSERT(a_full_holds_result, (q_full && out_stall_i) |=> out_valid_o)

endmodule

>>> design/szac_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module szac_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/szac_front.sv
// ----------------------------------------------------------------------------
// Classifier front end
// Accepts items, keeps channel health, reads thresholds and classifies polls.
// ----------------------------------------------------------------------------
module szac_front #(
  parameter int unsigned AREAS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [3:0]       cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             action_i,
  input  logic             channel_i,
  input  logic             reply_ok_i,
  input  logic [15:0]      distance_i,
  input  logic [3:0]       zone_inputs_i,
  input  logic [2:0]       area_slot_i,
  input  logic [1:0]       level_sel_i,
  input  logic [15:0]      threshold_i,
  input  logic             q_full_i,
  output logic             push_valid_o,
  output szac_pkg::result_t push_data_o
);
  import szac_pkg::*;

  localparam int unsigned AW = (AREAS > 1) ? $clog2(AREAS) : 1;

  logic        accept, poll_acc, wr_acc, slot_ok;
  logic [2:0]  area, area_m1;
  logic        area_ok;

  logic [3:0]  miss_lim_q;
  logic [15:0] dist_q  [NUM_CH];
  logic [15:0] dist_d  [NUM_CH];
  logic        alive_q [NUM_CH];
  logic        alive_d [NUM_CH];
  logic [3:0]  miss_q  [NUM_CH];
  logic [3:0]  miss_d  [NUM_CH];

  logic        s1_valid_q, s1_valid_d;
  logic [2:0]  s1_area_q;
  logic        s1_ok_q;
  logic [15:0] s1_dist_q  [NUM_CH];
  logic        s1_alive_q [NUM_CH];

  logic [15:0] thr [LEVELS][NUM_CH];
  logic [LEVELS-1:0] below;
  alarm_e      level;

  assign accept   = in_valid_i && !in_stall_o;
  assign poll_acc = accept && (action_i == ACT_POLL);
  assign wr_acc   = accept && (action_i == ACT_WRITE);
  assign slot_ok  = ({1'b0, area_slot_i} < 4'(AREAS));

  assign area    = ~zone_inputs_i[2:0];
  assign area_m1 = area - 3'd1;
  assign area_ok = (area != 3'd0) && ({1'b0, area} <= 4'(AREAS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_lim_q <= MISS_LIMIT_RST;
    end else if (cfg_we_i) begin
      miss_lim_q <= cfg_wdata_i;
    end
  end

  // Channel health update for the accepted poll
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      dist_d[c]  = dist_q[c];
      alive_d[c] = alive_q[c];
      miss_d[c]  = miss_q[c];
    end
    if (poll_acc) begin
      if (reply_ok_i) begin
        dist_d[channel_i]  = distance_i;
        alive_d[channel_i] = 1'b1;
        miss_d[channel_i]  = 4'd0;
      end else begin
        if (miss_q[channel_i] < MISS_MAX) begin
          miss_d[channel_i] = miss_q[channel_i] + 4'd1;
        end
        // Check both channels: a lowered limit can kill the idle one
        for (int c = 0; c < NUM_CH; c++) begin
          if (miss_d[c] > miss_lim_q) begin
            alive_d[c] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CH; c++) begin
        dist_q[c]  <= 16'd0;
        alive_q[c] <= 1'b0;
        miss_q[c]  <= 4'd0;
      end
    end else begin
      for (int c = 0; c < NUM_CH; c++) begin
        dist_q[c]  <= dist_d[c];
        alive_q[c] <= alive_d[c];
        miss_q[c]  <= miss_d[c];
      end
    end
  end

  // Threshold store: one RAM per level and channel, all read at the area row
  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
      logic we;
      assign we = wr_acc && slot_ok && (level_sel_i == 2'(l)) && (channel_i == 1'(c));
      szac_ram #(
        .WIDTH (16),
        .DEPTH (AREAS)
      ) u_thr (
        .clk_i   (clk_i),
        .we_i    (we),
        .waddr_i (area_slot_i[AW-1:0]),
        .wdata_i (threshold_i),
        .re_i    (poll_acc),
        .raddr_i (area_m1[AW-1:0]),
        .rdata_o (thr[l][c])
      );
    end
  end

  assign push_valid_o = s1_valid_q && !q_full_i;
  assign in_stall_o   = s1_valid_q && q_full_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (push_valid_o) begin
      s1_valid_d = 1'b0;
    end
    if (poll_acc) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (poll_acc) begin
      s1_area_q <= area;
      s1_ok_q   <= area_ok;
      for (int c = 0; c < NUM_CH; c++) begin
        s1_dist_q[c]  <= dist_d[c];
        s1_alive_q[c] <= alive_d[c];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      below[l] = (s1_dist_q[0] < thr[l][0]) || (s1_dist_q[1] < thr[l][1]);
    end
  end

  // Level rules in priority order; inside a valid area a dead channel gives at least slow
  always_comb begin
    if (!s1_ok_q) begin
      level = LVL_CLEAR;
    end else if (below[2]) begin
      level = LVL_STOP;
    end else if (below[1] || !s1_alive_q[0] || !s1_alive_q[1]) begin
      level = LVL_SLOW;
    end else if (below[0]) begin
      level = LVL_WARN;
    end else begin
      level = LVL_CLEAR;
    end
  end

  always_comb begin
    push_data_o.alarm_level = level;
    push_data_o.area_index  = s1_area_q;
    push_data_o.area_active = (s1_area_q != 3'd0);
    push_data_o.drive_bits  = thermo(level);
    push_data_o.alive_flags = {s1_alive_q[1], s1_alive_q[0]};
    push_data_o.distance_a  = s1_dist_q[0];
    push_data_o.distance_b  = s1_dist_q[1];
  end

endmodule

>>> design/szac_queue.sv
// ----------------------------------------------------------------------------
// Classifier result queue
// Short FIFO that decouples the front end from the output handshake.
// ----------------------------------------------------------------------------
module szac_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  szac_pkg::result_t push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output szac_pkg::result_t head_o
);
  import szac_pkg::*;

  result_t            ent_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]    cnt_q, cnt_d;
  logic               pop;

  assign full_o      = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign head_o      = ent_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
